// ===== rtl/biq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad low-pass package
// Widths, register indexes and the configuration bundle shared by the
// biquad filter modules.
// ----------------------------------------------------------------------------
package biq_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 20;
   localparam int COEF_FRAC    = 16;
   localparam int WARMUP_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
   // Five products, one of them possibly negated at its minimum, need three extra bits.
   localparam int ACC_WIDTH  = PROD_WIDTH + 3;
   localparam int RND_WIDTH  = ACC_WIDTH - COEF_FRAC;

   localparam logic [COEF_WIDTH-1:0]   COEF_B0_RESET = COEF_WIDTH'(65536);
   localparam logic [WARMUP_WIDTH-1:0] WARMUP_RESET  = WARMUP_WIDTH'(100);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_B0        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_B1        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_B2        = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_A1        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_A2        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WARMUP_SAMPLES = 3'd5;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
      logic [WARMUP_WIDTH-1:0]      warmup_samples;
   } cfg_type;

endpackage

// ===== rtl/biq_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad configuration registers
// Holds the five coefficients and the warm-up length written over the
// configuration port.
// ----------------------------------------------------------------------------
module biq_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [biq_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [biq_pkg::COEF_WIDTH-1:0]        csr_wdata,
   output biq_pkg::cfg_type                      cfg
);
   import biq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_COEF_B0:        cfg_in.b0 = csr_wdata;
            CSR_COEF_B1:        cfg_in.b1 = csr_wdata;
            CSR_COEF_B2:        cfg_in.b2 = csr_wdata;
            CSR_COEF_A1:        cfg_in.a1 = csr_wdata;
            CSR_COEF_A2:        cfg_in.a2 = csr_wdata;
            CSR_WARMUP_SAMPLES: cfg_in.warmup_samples = csr_wdata[WARMUP_WIDTH-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.b0             <= COEF_B0_RESET;
         cfg_ff.b1             <= '0;
         cfg_ff.b2             <= '0;
         cfg_ff.a1             <= '0;
         cfg_ff.a2             <= '0;
         cfg_ff.warmup_samples <= WARMUP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/biq_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad arithmetic core
// Keeps the sample histories and warm-up count. Outputs x during warm-up and
// then the rounded, saturated direct form 1 output for the advancing sample.
// ----------------------------------------------------------------------------
module biq_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic signed [biq_pkg::SAMPLE_WIDTH-1:0] x,
   input  biq_pkg::cfg_type                      cfg,
   output logic signed [biq_pkg::SAMPLE_WIDTH-1:0] y,
   output logic                                  active
);
   import biq_pkg::*;

   localparam logic signed [RND_WIDTH-1:0] MAX_OUT =
      RND_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [RND_WIDTH-1:0] MIN_OUT = -MAX_OUT - RND_WIDTH'(1);
   localparam logic signed [ACC_WIDTH-1:0] HALF_LSB =
      ACC_WIDTH'(64'sd1 <<< (COEF_FRAC - 1));

   logic signed [SAMPLE_WIDTH-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic [WARMUP_WIDTH-1:0]        warm_cnt_ff;

   logic signed [PROD_WIDTH-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [ACC_WIDTH-1:0]    acc;
   logic signed [RND_WIDTH-1:0]    rnd;
   logic signed [SAMPLE_WIDTH-1:0] filt;

   always_comb begin
      p_b0 = PROD_WIDTH'(cfg.b0 * x);
      p_b1 = PROD_WIDTH'(cfg.b1 * x1_ff);
      p_b2 = PROD_WIDTH'(cfg.b2 * x2_ff);
      p_a1 = PROD_WIDTH'(cfg.a1 * y1_ff);
      p_a2 = PROD_WIDTH'(cfg.a2 * y2_ff);
      acc  = ACC_WIDTH'(p_b0) + ACC_WIDTH'(p_b1) + ACC_WIDTH'(p_b2)
           - ACC_WIDTH'(p_a1) - ACC_WIDTH'(p_a2) + HALF_LSB;
      rnd  = RND_WIDTH'(acc >>> COEF_FRAC);
      if (rnd > MAX_OUT) begin
         filt = MAX_OUT[SAMPLE_WIDTH-1:0];
      end else if (rnd < MIN_OUT) begin
         filt = MIN_OUT[SAMPLE_WIDTH-1:0];
      end else begin
         filt = rnd[SAMPLE_WIDTH-1:0];
      end
   end

   assign active = (warm_cnt_ff >= cfg.warmup_samples);
   assign y      = active ? filt : x;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff       <= '0;
         x2_ff       <= '0;
         y1_ff       <= '0;
         y2_ff       <= '0;
         warm_cnt_ff <= '0;
      end else if (advance) begin
         x2_ff <= x1_ff;
         x1_ff <= x;
         y2_ff <= y1_ff;
         y1_ff <= y;
         if (!active) begin
            warm_cnt_ff <= warm_cnt_ff + WARMUP_WIDTH'(1);
         end
      end
   end

endmodule

// ===== rtl/biquad_lowpass_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad low-pass filter
// Datapath: a transferred sample waits in the input register, and its result
// is offered from the result register. Throughput: one sample per cycle while
// results are taken, limited by feedback through the five products and the sum.
// Reset clears both histories and the warm-up count, and loads b0 = 1.0,
// the other coefficients 0 and a warm-up length of 100 samples.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [biq_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [biq_pkg::SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                                    rsp_filter_active,
   input  logic                                    csr_write_en,
   input  logic [biq_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [biq_pkg::COEF_WIDTH-1:0]          csr_wdata
);
   import biq_pkg::*;

   cfg_type cfg;

   logic                           in_vld_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic                           out_vld_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_sample_ff;
   logic                           out_active_ff;
   logic                           advance;
   logic signed [SAMPLE_WIDTH-1:0] core_y;
   logic                           core_active;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   biq_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   biq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .x       (in_sample_ff),
      .cfg     (cfg),
      .y       (core_y),
      .active  (core_active)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_sample_in;
      end
      if (advance) begin
         out_sample_ff <= core_y;
         out_active_ff <= core_active;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_sample_out    = out_sample_ff;
   assign rsp_filter_active = out_active_ff;

endmodule
